FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the load/store queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("load/store queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("load/store queue check failed");

`endif

FILE: sv/lsq_pkg.sv
// Shared constants, types and helper functions of the in-order load/store queue.
package lsq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int ENTRY_W     = 4;
	localparam int IDX_W       = (PTR_W > ENTRY_W) ? PTR_W : ENTRY_W;

	// Field widths.
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 32;
	localparam int DATA_W   = 32;
	localparam int ROB_W    = 6;
	localparam int PHYS_W   = 6;
	localparam int COMMIT_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_W-1:0] OP_ISSUE  = 2'd2;

	// Commit count that holds back a store at the head.
	localparam logic [COMMIT_W-1:0] COMMIT_BLOCK = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;

	// Address half of an entry, written by a push or an address update.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} addr_entry_t;

	// Remaining fields of an entry, written only by a push.
	typedef struct packed {
		logic                     store;
		logic [ROB_W-1:0]         rob;
		logic                     ready;
		logic signed [DATA_W-1:0] data;
		logic [PHYS_W-1:0]        dest;
	} info_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} lsq_cmd_t;

	// Next position of a circular pointer.
	function automatic ptr_t advance(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// True when an external entry index names a real entry.
	function automatic logic index_in_range(input logic [ENTRY_W-1:0] i);
		return 32'(i) < 32'(QUEUE_DEPTH);
	endfunction

	// External entry index as a pointer.
	function automatic ptr_t index_to_ptr(input logic [ENTRY_W-1:0] i);
		logic [IDX_W-1:0] w;
		w = IDX_W'(i);
		return w[PTR_W-1:0];
	endfunction

	// Pointer as an external entry index (low bits only).
	function automatic logic [ENTRY_W-1:0] ptr_to_index(input ptr_t p);
		logic [IDX_W-1:0] w;
		w = IDX_W'(p);
		return w[ENTRY_W-1:0];
	endfunction

endpackage

FILE: sv/lsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/lsq_ctrl.sv
// Controller of the load/store queue: transaction handshake and sequencing.
module lsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lsq_pkg::lsq_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Take a new transaction only when idle and the result register is free or emptying.
	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = (state_q == ST_EXEC);

	// State and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/lsq_dp.sv
// Datapath of the load/store queue: pointers, occupancy, entry storage and result register.
module lsq_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  lsq_pkg::lsq_cmd_t                         cmd,
	input  logic [lsq_pkg::OP_W-1:0]                  opcode,
	input  logic [lsq_pkg::ENTRY_W-1:0]               entry_index,
	input  logic [lsq_pkg::ADDR_W-1:0]                address,
	input  logic                                      address_known,
	input  logic                                      is_store,
	input  logic [lsq_pkg::ROB_W-1:0]                 rob_tag,
	input  logic                                      data_ready,
	input  logic signed [lsq_pkg::DATA_W-1:0]         store_data,
	input  logic [lsq_pkg::PHYS_W-1:0]                dest_phys,
	input  logic                                      mem_stalled,
	input  logic                                      rob_head_store,
	input  logic [lsq_pkg::COMMIT_W-1:0]              commits_now,
	output logic                                      push_ok,
	output logic [lsq_pkg::ENTRY_W-1:0]               push_slot,
	output logic                                      tail_free,
	output logic                                      queue_empty,
	output logic                                      issued,
	output logic                                      issued_store,
	output logic [lsq_pkg::ADDR_W-1:0]                issued_address,
	output logic signed [lsq_pkg::DATA_W-1:0]         issued_data,
	output logic [lsq_pkg::ROB_W-1:0]                 issued_rob_tag,
	output logic [lsq_pkg::PHYS_W-1:0]                issued_dest
);

	// Captured transaction.
	logic [lsq_pkg::OP_W-1:0]          opcode_q;
	logic [lsq_pkg::ENTRY_W-1:0]       entry_index_q;
	logic [lsq_pkg::ADDR_W-1:0]        address_q;
	logic                              address_known_q;
	logic                              is_store_q;
	logic [lsq_pkg::ROB_W-1:0]         rob_tag_q;
	logic                              data_ready_q;
	logic signed [lsq_pkg::DATA_W-1:0] store_data_q;
	logic [lsq_pkg::PHYS_W-1:0]        dest_phys_q;
	logic                              mem_stalled_q;
	logic                              rob_head_store_q;
	logic [lsq_pkg::COMMIT_W-1:0]      commits_now_q;

	// Queue control state.
	lsq_pkg::ptr_t                    head_q;
	lsq_pkg::ptr_t                    tail_q;
	logic [lsq_pkg::QUEUE_DEPTH-1:0]  busy_q;

	// Next-state values.
	lsq_pkg::ptr_t                    head_next;
	lsq_pkg::ptr_t                    tail_next;
	logic [lsq_pkg::QUEUE_DEPTH-1:0]  busy_next;
	logic                             push_go;
	logic                             update_go;
	logic                             issue_go;

	// Entry storage ports.
	logic                  addr_we;
	lsq_pkg::ptr_t         addr_waddr;
	lsq_pkg::addr_entry_t  addr_wdata;
	lsq_pkg::addr_entry_t  addr_rdata;
	lsq_pkg::info_entry_t  info_wdata;
	lsq_pkg::info_entry_t  info_rdata;

	// Capture the transaction when the controller accepts it.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q         <= opcode;
			entry_index_q    <= entry_index;
			address_q        <= address;
			address_known_q  <= address_known;
			is_store_q       <= is_store;
			rob_tag_q        <= rob_tag;
			data_ready_q     <= data_ready;
			store_data_q     <= store_data;
			dest_phys_q      <= dest_phys;
			mem_stalled_q    <= mem_stalled;
			rob_head_store_q <= rob_head_store;
			commits_now_q    <= commits_now;
		end
	end

	// Decide what the operation does, using the head entry read on acceptance.
	always_comb begin
		push_go   = cmd.execute && (opcode_q == lsq_pkg::OP_PUSH) && !busy_q[tail_q];
		update_go = cmd.execute && (opcode_q == lsq_pkg::OP_UPDATE)
			&& lsq_pkg::index_in_range(entry_index_q);
		issue_go  = 1'b0;
		if (cmd.execute && (opcode_q == lsq_pkg::OP_ISSUE) && busy_q[head_q]
			&& addr_rdata.valid && !mem_stalled_q) begin
			if (info_rdata.store) begin
				issue_go = info_rdata.ready && (commits_now_q != lsq_pkg::COMMIT_BLOCK)
					&& rob_head_store_q;
			end else begin
				issue_go = 1'b1;
			end
		end

		busy_next = busy_q;
		head_next = head_q;
		tail_next = tail_q;
		if (push_go) begin
			busy_next[tail_q] = 1'b1;
			tail_next         = lsq_pkg::advance(tail_q);
		end
		if (issue_go) begin
			busy_next[head_q] = 1'b0;
			head_next         = lsq_pkg::advance(head_q);
		end
	end

	// Storage write selection: a push fills the tail, an update names its entry.
	always_comb begin
		addr_we          = push_go || update_go;
		addr_waddr       = push_go ? tail_q : lsq_pkg::index_to_ptr(entry_index_q);
		addr_wdata.valid = push_go ? address_known_q : 1'b1;
		addr_wdata.addr  = address_q;
		info_wdata.store = is_store_q;
		info_wdata.rob   = rob_tag_q;
		info_wdata.ready = data_ready_q;
		info_wdata.data  = store_data_q;
		info_wdata.dest  = dest_phys_q;
	end

	lsq_ram #(
		.WIDTH($bits(lsq_pkg::addr_entry_t)),
		.DEPTH(lsq_pkg::QUEUE_DEPTH)
	) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (addr_waddr),
		.wdata (addr_wdata),
		.raddr (head_q),
		.rdata (addr_rdata)
	);

	lsq_ram #(
		.WIDTH($bits(lsq_pkg::info_entry_t)),
		.DEPTH(lsq_pkg::QUEUE_DEPTH)
	) u_info_ram (
		.clk   (clk),
		.we    (push_go),
		.waddr (tail_q),
		.wdata (info_wdata),
		.raddr (head_q),
		.rdata (info_rdata)
	);

	// Pointers and occupancy bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			busy_q <= '0;
		end else if (cmd.execute) begin
			head_q <= head_next;
			tail_q <= tail_next;
			busy_q <= busy_next;
		end
	end

	// Result register; fields that do not apply are zero.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			push_ok        <= push_go;
			push_slot      <= push_go ? lsq_pkg::ptr_to_index(tail_q) : '0;
			tail_free      <= !busy_next[tail_next];
			queue_empty    <= ~|busy_next;
			issued         <= issue_go;
			issued_store   <= issue_go ? info_rdata.store : 1'b0;
			issued_address <= issue_go ? addr_rdata.addr : '0;
			issued_data    <= issue_go ? info_rdata.data : '0;
			issued_rob_tag <= issue_go ? info_rdata.rob : '0;
			issued_dest    <= issue_go ? info_rdata.dest : '0;
		end
	end

endmodule

FILE: sv/in_order_load_store_queue.sv
// An accepted transaction is captured while the head entry is read from the entry
// storage (a registered read); the queue update follows, and no new transaction is
// taken until it is done and the result register is free or being emptied.
// Reset (arst_n low, asynchronous) empties the queue, zeroes both pointers and
// drops any pending result; entry storage is not cleared.
module in_order_load_store_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lsq_pkg::OP_W-1:0]          opcode,
	input  logic [lsq_pkg::ENTRY_W-1:0]       entry_index,
	input  logic [lsq_pkg::ADDR_W-1:0]        address,
	input  logic                              address_known,
	input  logic                              is_store,
	input  logic [lsq_pkg::ROB_W-1:0]         rob_tag,
	input  logic                              data_ready,
	input  logic signed [lsq_pkg::DATA_W-1:0] store_data,
	input  logic [lsq_pkg::PHYS_W-1:0]        dest_phys,
	input  logic                              mem_stalled,
	input  logic                              rob_head_store,
	input  logic [lsq_pkg::COMMIT_W-1:0]      commits_now,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              push_ok,
	output logic [lsq_pkg::ENTRY_W-1:0]       push_slot,
	output logic                              tail_free,
	output logic                              queue_empty,
	output logic                              issued,
	output logic                              issued_store,
	output logic [lsq_pkg::ADDR_W-1:0]        issued_address,
	output logic signed [lsq_pkg::DATA_W-1:0] issued_data,
	output logic [lsq_pkg::ROB_W-1:0]         issued_rob_tag,
	output logic [lsq_pkg::PHYS_W-1:0]        issued_dest
);

	lsq_pkg::lsq_cmd_t cmd;

	// Handshake and sequencing.
	lsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Queue state and result formation.
	lsq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.opcode         (opcode),
		.entry_index    (entry_index),
		.address        (address),
		.address_known  (address_known),
		.is_store       (is_store),
		.rob_tag        (rob_tag),
		.data_ready     (data_ready),
		.store_data     (store_data),
		.dest_phys      (dest_phys),
		.mem_stalled    (mem_stalled),
		.rob_head_store (rob_head_store),
		.commits_now    (commits_now),
		.push_ok        (push_ok),
		.push_slot      (push_slot),
		.tail_free      (tail_free),
		.queue_empty    (queue_empty),
		.issued         (issued),
		.issued_store   (issued_store),
		.issued_address (issued_address),
		.issued_data    (issued_data),
		.issued_rob_tag (issued_rob_tag),
		.issued_dest    (issued_dest)
	);

endmodule

FILE: sv/lsq_checker.sv
// Port-level checks of the load/store queue and their attachment to the top level.
`include "assert_macros.svh"

module lsq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              push_ok,
	input logic [lsq_pkg::ENTRY_W-1:0]       push_slot,
	input logic                              queue_empty,
	input logic                              issued,
	input logic [lsq_pkg::ADDR_W-1:0]        issued_address,
	input logic signed [lsq_pkg::DATA_W-1:0] issued_data
);

	// A pending result is held until it is taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// One transaction is worked on at a time.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

	// A successful push leaves at least one occupied entry.
	`ASSERT_IMPLIES(a_push_not_empty, clk, arst_n, out_valid && push_ok, !queue_empty)

	// A refused or absent push reports slot zero.
	`ASSERT_IMPLIES(a_slot_zero, clk, arst_n, out_valid && !push_ok, push_slot == '0)

	// Without an issue the memory fields are zero.
	`ASSERT_IMPLIES(a_issue_zero, clk, arst_n, out_valid && !issued,
		(issued_address == '0) && (issued_data == '0))

endmodule

bind in_order_load_store_queue lsq_checker u_lsq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.push_ok        (push_ok),
	.push_slot      (push_slot),
	.queue_empty    (queue_empty),
	.issued         (issued),
	.issued_address (issued_address),
	.issued_data    (issued_data)
);
